@@ rtl/core/rotary_knob_level_decoder_unit_assert.svh @@
// Assertion macros for the rotary knob level decoder.
`ifndef ROTARY_KNOB_LEVEL_DECODER_UNIT_ASSERT_SVH
`define ROTARY_KNOB_LEVEL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RKL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rkl assertion failed");

// Next-cycle implication, disabled during reset.
`define RKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rkl assertion failed");

`endif

@@ rtl/core/rkl_pkg.sv @@
// Package: types, codes and defaults of the rotary knob level decoder.
package rkl_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int LEVEL_W        = 7;
	localparam int CFG_DATA_W     = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int NUM_CNT        = 4;

	localparam logic [1:0] REQ_EDGE_A = 2'd0;
	localparam logic [1:0] REQ_EDGE_B = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAL_THRESH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 2'd2;

	localparam logic [7:0]         SAMPLE_COUNT_RST = 8'd30;
	localparam logic [7:0]         QUAL_THRESH_RST  = 8'd20;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 7'd100;

	// counter slots and edge flag bits share the same order
	localparam int CNT_A_FALL = 0;
	localparam int CNT_A_RISE = 1;
	localparam int CNT_B_FALL = 2;
	localparam int CNT_B_RISE = 3;

	localparam int DIR_UP   = 0;
	localparam int DIR_DOWN = 1;

	typedef struct packed {
		logic [7:0]         sample_count;
		logic [7:0]         qualify_threshold;
		logic [LEVEL_W-1:0] max_level;
	} rkl_cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [3:0]         edge_flags;
		logic [1:0]         dir_flags;
	} rkl_ctl_t;

endpackage

@@ rtl/core/rkl_if.sv @@
// Handshake interfaces for request and response beats.
interface rkl_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       pin_a;
	logic       pin_b;

	modport source (output valid, output req_type, output pin_a, output pin_b, input ready);
	modport sink   (input valid, input req_type, input pin_a, input pin_b, output ready);
endinterface

interface rkl_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] level;
	logic       level_event;

	modport source (output valid, output level, output level_event, input ready);
	modport sink   (input valid, input level, input level_event, output ready);
endinterface

@@ rtl/core/rkl_cfg.sv @@
// Configuration register file with reset defaults.
module rkl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [rkl_pkg::CFG_IDX_W-1:0]   index,
	input  logic [rkl_pkg::CFG_DATA_W-1:0]  wdata,
	output rkl_pkg::rkl_cfg_t               cfg
);
	import rkl_pkg::*;

	rkl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count      <= SAMPLE_COUNT_RST;
			cfg_q.qualify_threshold <= QUAL_THRESH_RST;
			cfg_q.max_level         <= MAX_LEVEL_RST;
		end else if (we) begin
			case (index)
				REG_SAMPLE_COUNT: cfg_q.sample_count      <= wdata;
				REG_QUAL_THRESH:  cfg_q.qualify_threshold <= wdata;
				REG_MAX_LEVEL:    cfg_q.max_level         <= wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ rtl/core/rkl_step.sv @@
// Next-state and result logic for one decoder beat.
module rkl_step #(
	parameter int COUNT_BITS = rkl_pkg::COUNT_BITS_DEF
) (
	input  rkl_pkg::rkl_cfg_t                               cfg,
	input  rkl_pkg::rkl_ctl_t                               ctl,
	input  logic [rkl_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]     cnt,
	input  logic [1:0]                                      req_type,
	input  logic                                            pin_a,
	input  logic                                            pin_b,
	output rkl_pkg::rkl_ctl_t                               ctl_nxt,
	output logic [rkl_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]     cnt_nxt,
	output logic                                            level_event
);
	import rkl_pkg::*;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
	                                                  input logic [7:0] inc);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS+1)'(inc);
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

	logic [COUNT_BITS-1:0] thr;
	logic                  step_ok;

	assign thr     = COUNT_BITS'(cfg.qualify_threshold);
	assign step_ok = cfg.sample_count > cfg.qualify_threshold;

	always_comb begin
		ctl_nxt     = ctl;
		cnt_nxt     = cnt;
		level_event = 1'b0;
		case (req_type)
			REQ_EDGE_A: begin
				if (!pin_a) cnt_nxt[CNT_A_FALL] = sat_add(cnt[CNT_A_FALL], cfg.sample_count);
				if (cnt_nxt[CNT_A_FALL] > thr && pin_b) begin
					cnt_nxt[CNT_A_FALL]             = '0;
					ctl_nxt.edge_flags[CNT_A_FALL]  = 1'b1;
				end
				if (pin_a) cnt_nxt[CNT_A_RISE] = sat_add(cnt[CNT_A_RISE], cfg.sample_count);
				if (cnt_nxt[CNT_A_RISE] > thr && !pin_b) begin
					cnt_nxt[CNT_A_RISE]             = '0;
					ctl_nxt.edge_flags[CNT_A_RISE]  = 1'b1;
				end
				if (ctl_nxt.dir_flags[DIR_DOWN] && (&ctl_nxt.edge_flags)) begin
					ctl_nxt.edge_flags[CNT_B_FALL] = 1'b0;
					ctl_nxt.edge_flags[CNT_B_RISE] = 1'b0;
					ctl_nxt.dir_flags[DIR_DOWN]    = 1'b0;
				end
				if (ctl_nxt.edge_flags[CNT_A_FALL] && !pin_a && pin_b && step_ok) begin
					ctl_nxt.dir_flags[DIR_UP] = 1'b1;
					if (ctl.level >= cfg.max_level) ctl_nxt.level = cfg.max_level;
					else ctl_nxt.level = ctl.level + LEVEL_W'(1);
					level_event = 1'b1;
				end
			end
			REQ_EDGE_B: begin
				if (!pin_b) cnt_nxt[CNT_B_FALL] = sat_add(cnt[CNT_B_FALL], cfg.sample_count);
				if (cnt_nxt[CNT_B_FALL] > thr && pin_a) begin
					cnt_nxt[CNT_B_FALL]             = '0;
					ctl_nxt.edge_flags[CNT_B_FALL]  = 1'b1;
				end
				if (pin_b) cnt_nxt[CNT_B_RISE] = sat_add(cnt[CNT_B_RISE], cfg.sample_count);
				if (cnt_nxt[CNT_B_RISE] > thr && !pin_a) begin
					cnt_nxt[CNT_B_RISE]             = '0;
					ctl_nxt.edge_flags[CNT_B_RISE]  = 1'b1;
				end
				if (ctl_nxt.dir_flags[DIR_UP] && (&ctl_nxt.edge_flags)) begin
					ctl_nxt.edge_flags[CNT_A_FALL] = 1'b0;
					ctl_nxt.edge_flags[CNT_A_RISE] = 1'b0;
					ctl_nxt.dir_flags[DIR_UP]      = 1'b0;
				end
				if (ctl_nxt.edge_flags[CNT_B_FALL] && pin_a && !pin_b && step_ok) begin
					ctl_nxt.dir_flags[DIR_DOWN] = 1'b1;
					if (ctl.level != '0) begin
						ctl_nxt.level = ctl.level - LEVEL_W'(1);
						level_event   = 1'b1;
					end
				end
			end
			REQ_CLEAR: begin
				ctl_nxt.level = '0;
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/rotary_knob_level_decoder_unit.sv @@
// Top level of the rotary knob level decoder: input stage, state, result stage.
//
// channel | dir | payload                      | handshake
// req     | in  | req_type[1:0], pin_a, pin_b  | valid/ready
// rsp     | out | level[6:0], level_event      | valid/ready
// cfg     | in  | cfg_index[1:0], cfg_wdata[7:0]| cfg_we, no wait
//
// One beat per cycle sustained while rsp is not stalled; the request beat is registered
// in the input stage and its result in the result stage, which drives rsp.valid.
// The state update and result are computed combinationally between the input and result stages.
// arst_n resets the state to zero and the registers to their defaults.
// A stalled rsp holds the result stage; req keeps accepting while the input stage is free.
module rotary_knob_level_decoder_unit #(
	parameter int COUNT_BITS = rkl_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rkl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rkl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	rkl_req_if.sink                         req,
	rkl_rsp_if.source                       rsp
);
	import rkl_pkg::*;

	`include "rotary_knob_level_decoder_unit_assert.svh"

	rkl_cfg_t                             cfg;
	rkl_ctl_t                             ctl_q, ctl_nxt;
	logic [NUM_CNT-1:0][COUNT_BITS-1:0]   cnt_q, cnt_nxt;
	logic                                 ev_nxt;

	logic                 valid_s1;
	logic [1:0]           req_type_s1;
	logic                 pin_a_s1, pin_b_s1;
	logic                 valid_s2;
	logic [LEVEL_W-1:0]   level_s2;
	logic                 level_event_s2;
	logic                 advance;
	logic                 fire_s1;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign fire_s1   = valid_s1 && advance;

	rkl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	rkl_step #(.COUNT_BITS(COUNT_BITS)) u_step (
		.cfg         (cfg),
		.ctl         (ctl_q),
		.cnt         (cnt_q),
		.req_type    (req_type_s1),
		.pin_a       (pin_a_s1),
		.pin_b       (pin_b_s1),
		.ctl_nxt     (ctl_nxt),
		.cnt_nxt     (cnt_nxt),
		.level_event (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			pin_a_s1    <= req.pin_a;
			pin_b_s1    <= req.pin_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			cnt_q <= '0;
		end else if (fire_s1) begin
			ctl_q <= ctl_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			level_s2       <= ctl_nxt.level;
			level_event_s2 <= ev_nxt;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.level       = level_s2;
	assign rsp.level_event = level_event_s2;

	`RKL_ASSERT_NOW(a_ready_only_on_stall, clk, arst_n, !req.ready, valid_s1 && valid_s2 && !rsp.ready)
	`RKL_ASSERT_NEXT(a_clear_result, clk, arst_n, fire_s1 && req_type_s1 == REQ_CLEAR, rsp.valid && rsp.level == '0 && !rsp.level_event)
	`RKL_ASSERT_NEXT(a_state_holds, clk, arst_n, !fire_s1, $stable(ctl_q) && $stable(cnt_q))
endmodule
